/* hdl/fst_pkg.sv */
// Shared types and constants for the flow sequence tracker.
package fst_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [31:0] PROTO_VERSION       = 32'd7;
   localparam logic [31:0] IDLE_LIMIT          = 32'd120;
   localparam logic [6:0]  MIN_LEN_CONDENSED   = 7'd22;
   localparam logic [6:0]  MIN_LEN_NORMAL      = 7'd24;
   localparam logic [5:0]  REPLY_LEN_CONDENSED = 6'd38;
   localparam logic [5:0]  REPLY_LEN_NORMAL    = 6'd40;

   localparam int REQ_W = 320;
   localparam int RSP_W = 264;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_PERCENT     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONDENSED_FORMAT = 1'd1;

   typedef struct packed {
      logic [3:0]  pad;
      logic [6:0]  drop_draw;
      logic [29:0] now_nsec;
      logic [31:0] now_sec;
      logic [63:0] client_nsec;
      logic [63:0] client_sec;
      logic [31:0] version_word;
      logic [31:0] seq_num;
      logic [6:0]  pkt_length;
      logic [15:0] src_port;
      logic [31:0] src_addr;
   } req_beat_type;

   typedef struct packed {
      logic        pad;
      logic [31:0] late_max_seq;
      logic        late_flag;
      logic        flow_tracked;
      logic [29:0] server_nsec;
      logic [31:0] server_sec;
      logic [63:0] reply_client_nsec;
      logic [63:0] reply_client_sec;
      logic [31:0] reply_seq;
      logic [5:0]  reply_length;
      logic        reply_valid;
   } rsp_beat_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] port;
      logic [31:0] max_seq;
      logic [31:0] last_seen;
   } entry_type;

   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_entry;
   } tbl_req_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } tbl_rsp_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] port;
      logic [31:0] seq;
      logic [31:0] now;
   } eng_key_type;

   typedef struct packed {
      logic        start;
      eng_key_type key;
   } eng_cmd_type;

   typedef struct packed {
      logic        done;
      logic        tracked;
      logic        late;
      logic [31:0] late_max;
   } eng_res_type;

endpackage

/* hdl/fst_table.sv */
// Flow table storage: entry memory with registered read and per-entry valid bits.
module fst_table (
   input  logic                 clock,
   input  logic                 reset,
   input  fst_pkg::tbl_req_type tbl_req,
   output fst_pkg::tbl_rsp_type tbl_rsp
);
   import fst_pkg::*;

   entry_type               mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   entry_type               rd_entry_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.wr_addr] <= tbl_req.wr_entry;
      end
      rd_entry_ff <= mem[tbl_req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[tbl_req.rd_addr];
         if (tbl_req.wr_en) begin
            valid_ff[tbl_req.wr_addr] <= 1'b1;
         end
      end
   end

   assign tbl_rsp.valid = rd_valid_ff;
   assign tbl_rsp.entry = rd_entry_ff;

endmodule

/* hdl/fst_engine.sv */
// Lookup sequencer: scans the table with one key comparator, then updates the found or a free entry, if any.
module fst_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  fst_pkg::eng_cmd_type eng_cmd,
   output fst_pkg::eng_res_type eng_res,
   output fst_pkg::tbl_req_type tbl_req,
   input  fst_pkg::tbl_rsp_type tbl_rsp
);
   import fst_pkg::*;

   localparam logic [1:0] E_IDLE = 2'd0;
   localparam logic [1:0] E_SCAN = 2'd1;
   localparam logic [1:0] E_UPD  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   entry_type        ent_ff, ent_in;
   eng_key_type      key_ff, key_in;
   eng_res_type      res_ff, res_in;

   logic        issue_en;
   logic        hit;
   logic        last_rd;
   logic [31:0] age;
   logic [31:0] max_eff;
   logic        grow;

   assign issue_en = (state_ff == E_SCAN) && (scan_ff < CNT_W'(TABLE_ENTRIES));
   assign hit      = rd_pend_ff && tbl_rsp.valid &&
                     (tbl_rsp.entry.addr == key_ff.addr) &&
                     (tbl_rsp.entry.port == key_ff.port);
   assign last_rd  = rd_pend_ff && (rd_idx_ff == IDX_W'(TABLE_ENTRIES - 1));

   assign age     = key_ff.now - ent_ff.last_seen;
   assign max_eff = (age > IDLE_LIMIT) ? 32'd0 : ent_ff.max_seq;
   assign grow    = key_ff.seq > max_eff;

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      rd_pend_in    = issue_en;
      rd_idx_in     = scan_ff[IDX_W-1:0];
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      slot_in       = slot_ff;
      ent_in        = ent_ff;
      key_in        = key_ff;
      res_in        = res_ff;
      res_in.done   = 1'b0;

      tbl_req.rd_addr           = scan_ff[IDX_W-1:0];
      tbl_req.wr_en             = 1'b0;
      tbl_req.wr_addr           = slot_ff;
      tbl_req.wr_entry.addr     = key_ff.addr;
      tbl_req.wr_entry.port     = key_ff.port;
      tbl_req.wr_entry.max_seq  = grow ? key_ff.seq : max_eff;
      tbl_req.wr_entry.last_seen = grow ? key_ff.now : ent_ff.last_seen;

      unique case (state_ff)
         E_IDLE: begin
            if (eng_cmd.start) begin
               key_in        = eng_cmd.key;
               scan_in       = '0;
               free_found_in = 1'b0;
               state_in      = E_SCAN;
            end
         end
         E_SCAN: begin
            if (issue_en) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (hit) begin
               slot_in  = rd_idx_ff;
               ent_in   = tbl_rsp.entry;
               state_in = E_UPD;
            end else begin
               if (rd_pend_ff && !tbl_rsp.valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
               if (last_rd) begin
                  if (free_found_ff || !tbl_rsp.valid) begin
                     slot_in           = free_found_ff ? free_idx_ff : rd_idx_ff;
                     ent_in.addr       = key_ff.addr;
                     ent_in.port       = key_ff.port;
                     ent_in.max_seq    = 32'd0;
                     ent_in.last_seen  = key_ff.now;
                     state_in          = E_UPD;
                  end else begin
                     res_in.done     = 1'b1;
                     res_in.tracked  = 1'b0;
                     res_in.late     = 1'b0;
                     res_in.late_max = 32'd0;
                     state_in        = E_IDLE;
                  end
               end
            end
         end
         E_UPD: begin
            tbl_req.wr_en   = 1'b1;
            res_in.done     = 1'b1;
            res_in.tracked  = 1'b1;
            res_in.late     = (max_eff != 32'd0) && (key_ff.seq < max_eff);
            res_in.late_max = res_in.late ? max_eff : 32'd0;
            state_in        = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= E_IDLE;
         rd_pend_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         res_ff.done   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pend_ff    <= rd_pend_in;
         free_found_ff <= free_found_in;
         res_ff.done   <= res_in.done;
      end
      scan_ff         <= scan_in;
      rd_idx_ff       <= rd_idx_in;
      free_idx_ff     <= free_idx_in;
      slot_ff         <= slot_in;
      ent_ff          <= ent_in;
      key_ff          <= key_in;
      res_ff.tracked  <= res_in.tracked;
      res_ff.late     <= res_in.late;
      res_ff.late_max <= res_in.late_max;
   end

   assign eng_res = res_ff;

endmodule

/* hdl/flow_sequence_tracker_core.sv */
// Top level of the flow sequence tracker: request filter, lookup engine, reply register.
//
// Takes one timestamp request per beat, filters it (drop rate, length, version), tracks
// its flow in a table of fst_pkg::TABLE_ENTRIES entries and returns one reply beat.
// A filtered request skips the lookup: its all-zero reply goes from the hold register to
// the output register. A kept request is looked up by the engine, which reads the table
// memory one entry per cycle: a flow found at entry i ends the scan there, while a new or
// untracked flow scans the whole table until the last entry has been read. One request
// is in work at a time; req_tready rises again the cycle after the reply is loaded into
// the output register, which can hold it while the next request is already being taken.
// A stalled output register holds the finished reply back and keeps req_tready low.
module flow_sequence_tracker_core (
   input  logic                                clock,
   input  logic                                reset,
   // src_addr, src_port, pkt_length, seq_num, version_word, client_sec,
   // client_nsec, now_sec, now_nsec, drop_draw, zero pad
   input  logic [fst_pkg::REQ_W-1:0]           req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // reply_valid, reply_length, reply_seq, reply_client_sec, reply_client_nsec,
   // server_sec, server_nsec, flow_tracked, late_flag, late_max_seq, zero pad
   output logic [fst_pkg::RSP_W-1:0]           rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [fst_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [fst_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import fst_pkg::*;

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_RUN  = 2'd1;
   localparam logic [1:0] T_OUT  = 2'd2;

   logic [1:0]   state_ff, state_in;
   logic [6:0]   drop_pct_ff;
   logic         cond_ff;
   rsp_beat_type hold_ff, hold_in;
   rsp_beat_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   req_beat_type req;
   logic         req_fire;
   logic         drop;
   logic         out_free;
   eng_cmd_type  eng_cmd;
   eng_res_type  eng_res;
   tbl_req_type  tbl_req;
   tbl_rsp_type  tbl_rsp;

   assign req        = req_beat_type'(req_tdata);
   assign req_tready = (state_ff == T_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      drop = (req.pkt_length == 7'd0) || (req.drop_draw < drop_pct_ff);
      if (cond_ff) begin
         if (req.pkt_length < MIN_LEN_CONDENSED ||
             {16'd0, req.version_word[15:0]} != PROTO_VERSION) begin
            drop = 1'b1;
         end
      end else begin
         if (req.pkt_length < MIN_LEN_NORMAL || req.version_word != PROTO_VERSION) begin
            drop = 1'b1;
         end
      end
   end

   assign eng_cmd.start    = req_fire && !drop;
   assign eng_cmd.key.addr = req.src_addr;
   assign eng_cmd.key.port = req.src_port;
   assign eng_cmd.key.seq  = req.seq_num;
   assign eng_cmd.key.now  = req.now_sec;

   always_comb begin
      state_in     = state_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         T_IDLE: begin
            if (req_fire) begin
               hold_in = '0;
               if (!drop) begin
                  hold_in.reply_valid       = 1'b1;
                  hold_in.reply_length      = cond_ff ? REPLY_LEN_CONDENSED
                                                      : REPLY_LEN_NORMAL;
                  hold_in.reply_seq         = req.seq_num;
                  hold_in.reply_client_sec  = req.client_sec;
                  hold_in.reply_client_nsec = req.client_nsec;
                  hold_in.server_sec        = req.now_sec;
                  hold_in.server_nsec       = req.now_nsec;
               end
               state_in = drop ? T_OUT : T_RUN;
            end
         end
         T_RUN: begin
            if (eng_res.done) begin
               hold_in.flow_tracked = eng_res.tracked;
               hold_in.late_flag    = eng_res.late;
               hold_in.late_max_seq = eng_res.late_max;
               state_in             = T_OUT;
            end
         end
         T_OUT: begin
            if (out_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         drop_pct_ff  <= 7'd0;
         cond_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_DROP_PERCENT:     drop_pct_ff <= csr_wdata;
               CSR_CONDENSED_FORMAT: cond_ff     <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tdata  = RSP_W'(rsp_ff);
   assign rsp_tvalid = rsp_valid_ff;

   fst_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .eng_cmd (eng_cmd),
      .eng_res (eng_res),
      .tbl_req (tbl_req),
      .tbl_rsp (tbl_rsp)
   );

   fst_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .tbl_rsp (tbl_rsp)
   );

endmodule

/* hdl/fst_checker.sv */
// Port-level checks for the flow sequence tracker, bound to the top level.
module fst_checker (
   input logic                           clock,
   input logic                           reset,
   input logic [fst_pkg::RSP_W-1:0]      rsp_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready
);
   import fst_pkg::*;

   rsp_beat_type rsp;
   assign rsp = rsp_beat_type'(rsp_tdata);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("reply beat changed while stalled");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.reply_valid |-> rsp_tdata == '0)
      else $error("dropped reply carries nonzero fields");

   a_reply_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.reply_valid |->
         rsp.reply_length == REPLY_LEN_CONDENSED || rsp.reply_length == REPLY_LEN_NORMAL)
      else $error("bad reply length");

   a_late_tracked: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.late_flag |-> rsp.flow_tracked && rsp.late_max_seq != 32'd0)
      else $error("late flag without tracked flow");

   a_late_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.late_flag |-> rsp.late_max_seq == 32'd0)
      else $error("late max set without late flag");

endmodule

bind flow_sequence_tracker_core fst_checker u_fst_checker (.*);

/* bench/testbench.sv */
// Self-checking testbench for flow_sequence_tracker_core: filtering, flow history, full table.
`timescale 1ns / 100ps

module testbench;
   import fst_pkg::*;

   localparam int POOL_FLOWS     = 48;
   localparam int DRAIN_CYCLES   = TABLE_ENTRIES + 8;
   localparam int HOLD_CYCLES    = 3 * TABLE_ENTRIES;
   localparam int WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + TABLE_ENTRIES + 16);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_W-1:0]      req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   flow_sequence_tracker_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // predicted block state
   logic [6:0]  cfg_drop_pct;
   logic        cfg_condensed;
   logic        flow_valid    [TABLE_ENTRIES];
   logic [31:0] flow_addr     [TABLE_ENTRIES];
   logic [15:0] flow_port     [TABLE_ENTRIES];
   logic [31:0] flow_max_seq  [TABLE_ENTRIES];
   logic [31:0] flow_seen     [TABLE_ENTRIES];

   rsp_beat_type pending_replies[$];
   int           mismatch_cnt = 0;
   int           quiet_cycles = 0;

   // stimulus state
   logic [31:0] cur_now;
   logic [31:0] pool_addr [POOL_FLOWS];
   logic [15:0] pool_port [POOL_FLOWS];
   logic [31:0] pool_seq  [POOL_FLOWS];
   logic        tx_idle_en = 1'b1;
   logic        rx_idle_en = 1'b1;
   logic        hold_request = 1'b0;

   function automatic rsp_beat_type predict_reply(input req_beat_type r);
      rsp_beat_type o;
      logic         keep;
      int           slot;
      logic [31:0]  age;
      o = '0;
      keep = (r.pkt_length != 7'd0) && (r.drop_draw >= cfg_drop_pct);
      if (cfg_condensed) begin
         keep = keep && (r.pkt_length >= MIN_LEN_CONDENSED)
                && (r.version_word[15:0] == PROTO_VERSION[15:0]);
      end else begin
         keep = keep && (r.pkt_length >= MIN_LEN_NORMAL)
                && (r.version_word == PROTO_VERSION);
      end
      if (!keep) return o;
      slot = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (flow_valid[i] && flow_addr[i] == r.src_addr && flow_port[i] == r.src_port) begin
            slot = i;
            break;
         end
      end
      if (slot < 0) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!flow_valid[i]) begin
               flow_valid[i]   = 1'b1;
               flow_addr[i]    = r.src_addr;
               flow_port[i]    = r.src_port;
               flow_max_seq[i] = '0;
               flow_seen[i]    = r.now_sec;
               slot = i;
               break;
            end
         end
      end
      if (slot >= 0) begin
         o.flow_tracked = 1'b1;
         age = r.now_sec - flow_seen[slot];
         if (age > IDLE_LIMIT) flow_max_seq[slot] = '0;
         if (flow_max_seq[slot] != 0 && r.seq_num < flow_max_seq[slot]) begin
            o.late_flag    = 1'b1;
            o.late_max_seq = flow_max_seq[slot];
         end
         if (r.seq_num > flow_max_seq[slot]) begin
            flow_max_seq[slot] = r.seq_num;
            flow_seen[slot]    = r.now_sec;
         end
      end
      o.reply_valid       = 1'b1;
      o.reply_length      = cfg_condensed ? REPLY_LEN_CONDENSED : REPLY_LEN_NORMAL;
      o.reply_seq         = r.seq_num;
      o.reply_client_sec  = r.client_sec;
      o.reply_client_nsec = r.client_nsec;
      o.server_sec        = r.now_sec;
      o.server_nsec       = r.now_nsec;
      return o;
   endfunction

   function automatic req_beat_type good_req(input logic [31:0] addr, input logic [15:0] port,
                                             input logic [31:0] seq);
      req_beat_type r;
      r = '0;
      r.src_addr     = addr;
      r.src_port     = port;
      r.seq_num      = seq;
      r.pkt_length   = 7'($urandom_range(cfg_condensed ? 22 : 24, 127));
      r.version_word = PROTO_VERSION;
      if (cfg_condensed) r.version_word[31:16] = 16'($urandom);
      r.client_sec   = {$urandom, $urandom};
      r.client_nsec  = {$urandom, $urandom};
      r.now_sec      = cur_now;
      r.now_nsec     = 30'($urandom);
      r.drop_draw    = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                                   : 7'($urandom_range(0, 99));
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_cnt++;
      end
   endtask

   task automatic send_req(input req_beat_type r);
      req_tdata  <= r;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_replies.push_back(predict_reply(r));
      if (tx_idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DROP_PERCENT:     cfg_drop_pct  = val;
         CSR_CONDENSED_FORMAT: cfg_condensed = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic advance_now();
      int k;
      k = $urandom_range(0, 99);
      if (k < 80)      cur_now += $urandom_range(0, 4);
      else if (k < 95) cur_now += $urandom_range(100, 140);
      else             cur_now = $urandom;
   endtask

   task automatic random_item(input int fresh_pct);
      req_beat_type r;
      int           pick, k, s;
      logic [31:0]  seq;
      logic [6:0]   min_len;
      advance_now();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         for (int i = 0; i < 10; i++) r[i*32 +: 32] = $urandom;
         r.pad = '0;
      end else if ($urandom_range(0, 99) < fresh_pct) begin
         r = good_req($urandom, 16'($urandom), $urandom);
      end else begin
         k = $urandom_range(0, POOL_FLOWS - 1);
         s = $urandom_range(0, 99);
         if (s < 60)      seq = pool_seq[k] + $urandom_range(0, 8) - 3;
         else if (s < 75) seq = pool_seq[k] + 1;
         else if (s < 85) seq = $urandom;
         else if (s < 90) seq = '0;
         else             seq = pool_seq[k] - $urandom_range(1, 1000);
         if (seq > pool_seq[k]) pool_seq[k] = seq;
         r = good_req(pool_addr[k], pool_port[k], seq);
      end
      if (pick >= 92) begin
         min_len = cfg_condensed ? MIN_LEN_CONDENSED : MIN_LEN_NORMAL;
         case ($urandom_range(0, 3))
            0: r.pkt_length = '0;
            1: r.pkt_length = 7'($urandom_range(1, int'(min_len) - 1));
            2: r.version_word[$urandom_range(0, 31)] ^= 1'b1;
            default: begin
               if (cfg_drop_pct != 0)
                  r.drop_draw = 7'($urandom_range(0, int'(cfg_drop_pct) - 1));
               else
                  r.pkt_length = '0;
            end
         endcase
      end
      send_req(r);
   endtask

   task automatic test_filtering();
      req_beat_type r;
      settle();
      write_csr(CSR_DROP_PERCENT, '0);
      write_csr(CSR_CONDENSED_FORMAT, '0);
      cur_now = 32'd1000;
      r = good_req('0, '0, 32'd5);
      r.pkt_length = 7'd0;
      send_req(r);
      r.pkt_length = 7'd23;
      send_req(r);
      r.pkt_length = 7'd24;
      send_req(r);
      r.pkt_length = 7'd40;
      r.version_word = 32'd8;
      send_req(r);
      r.version_word = 32'h0001_0007;
      send_req(r);
      r.version_word = PROTO_VERSION;
      r.pkt_length = 7'd127;
      r.seq_num = 32'd0;
      send_req(r);
      settle();
      write_csr(CSR_CONDENSED_FORMAT, 7'd1);
      r = good_req($urandom, 16'($urandom), 32'd9);
      r.pkt_length = 7'd21;
      send_req(r);
      r.pkt_length = 7'd22;
      r.version_word = 32'hABCD_0007;
      send_req(r);
      r.version_word = 32'h0000_0017;
      send_req(r);
      settle();
      write_csr(CSR_CONDENSED_FORMAT, '0);
   endtask

   task automatic test_drop_rate();
      req_beat_type r;
      settle();
      write_csr(CSR_DROP_PERCENT, 7'd50);
      r = good_req($urandom, 16'($urandom), 32'd77);
      r.drop_draw = 7'd49;
      send_req(r);
      r.drop_draw = 7'd50;
      send_req(r);
      r.drop_draw = 7'd127;
      send_req(r);
      settle();
      write_csr(CSR_DROP_PERCENT, 7'd100);
      r.drop_draw = 7'd99;
      send_req(r);
      r.drop_draw = 7'd100;
      send_req(r);
      settle();
      write_csr(CSR_DROP_PERCENT, '0);
      r.drop_draw = 7'd0;
      send_req(r);
   endtask

   // late beats, equal sequence, idle limit at and past 120 s across the 2^32 wrap
   task automatic test_flow_history();
      req_beat_type r;
      cur_now = 32'hFFFF_FFA0;
      r = good_req('1, '1, 32'd100);
      r.client_sec  = '1;
      r.client_nsec = '1;
      r.now_nsec    = '1;
      send_req(r);
      r = good_req('1, '1, 32'd50);
      r.client_sec  = '0;
      r.client_nsec = '0;
      r.now_nsec    = '0;
      send_req(r);
      send_req(good_req('1, '1, 32'd100));
      send_req(good_req('1, '1, 32'hFFFF_FFFF));
      cur_now += 32'd120;
      send_req(good_req('1, '1, 32'd1));
      cur_now += 32'd1;
      send_req(good_req('1, '1, 32'd1));
      send_req(good_req(32'h8000_0001, 16'h8001, '0));
   endtask

   task automatic test_random_traffic(input int n, input logic [6:0] drop, input logic cond,
                                      input int fresh_pct);
      settle();
      write_csr(CSR_DROP_PERCENT, drop);
      write_csr(CSR_CONDENSED_FORMAT, 7'(cond));
      repeat (n) random_item(fresh_pct);
   endtask

   task automatic test_table_full();
      test_random_traffic(450, '0, 1'b0, 70);
   endtask

   task automatic test_backpressure();
      settle();
      tx_idle_en   = 1'b0;
      hold_request = 1'b1;
      repeat (12) random_item(10);
      tx_idle_en   = 1'b1;
   endtask

   task automatic test_no_idling();
      settle();
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      test_random_traffic(150, '0, 1'b1, 5);
   endtask

   // result side: ready with random stalls, one long hold on request
   initial begin
      rsp_beat_type got, want;
      int           stall_left, hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_replies.size() == 0) begin
               $error("reply beat with nothing expected");
               mismatch_cnt++;
            end else begin
               want = pending_replies.pop_front();
               check_field("reply_valid", 64'(want.reply_valid), 64'(got.reply_valid));
               check_field("reply_length", 64'(want.reply_length), 64'(got.reply_length));
               check_field("reply_seq", 64'(want.reply_seq), 64'(got.reply_seq));
               check_field("reply_client_sec", want.reply_client_sec, got.reply_client_sec);
               check_field("reply_client_nsec", want.reply_client_nsec,
                           got.reply_client_nsec);
               check_field("server_sec", 64'(want.server_sec), 64'(got.server_sec));
               check_field("server_nsec", 64'(want.server_nsec), 64'(got.server_nsec));
               check_field("flow_tracked", 64'(want.flow_tracked), 64'(got.flow_tracked));
               check_field("late_flag", 64'(want.late_flag), 64'(got.late_flag));
               check_field("late_max_seq", 64'(want.late_max_seq), 64'(got.late_max_seq));
            end
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_tdata  <= '0;
      req_tvalid <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      cfg_drop_pct  = '0;
      cfg_condensed = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         flow_valid[i]   = 1'b0;
         flow_addr[i]    = '0;
         flow_port[i]    = '0;
         flow_max_seq[i] = '0;
         flow_seen[i]    = '0;
      end
      for (int i = 0; i < POOL_FLOWS; i++) begin
         pool_addr[i] = $urandom;
         pool_port[i] = 16'($urandom);
         pool_seq[i]  = $urandom;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_filtering();
      test_drop_rate();
      test_flow_history();
      cur_now = 32'hFFFF_8000;
      test_random_traffic(500, '0, 1'b0, 3);
      test_random_traffic(400, 7'($urandom_range(1, 99)), 1'b1, 3);
      test_random_traffic(100, 7'd100, 1'b0, 3);
      test_table_full();
      test_backpressure();
      test_random_traffic(400, 7'($urandom_range(0, 100)), 1'($urandom), 10);
      test_no_idling();
      settle();

      if (mismatch_cnt == 0 && pending_replies.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/fst_pkg.sv
hdl/fst_table.sv
hdl/fst_engine.sv
hdl/flow_sequence_tracker_core.sv
hdl/fst_checker.sv
bench/testbench.sv
